// ===== design/fbba_pkg.sv =====
// ----------------------------------------------------------------------------
// fbba_pkg: shared types and constants of the free block bitmap allocator
// Operation and status codes, the sequencer states and the default sizes.
// ----------------------------------------------------------------------------
package fbba_pkg;

    // Default sizes of the bitmap store.
    localparam int DEF_MAX_BLOCKS    = 4096;
    localparam int DEF_MAP_WORD_BITS = 32;

    // Widths of the request, result and register fields.
    localparam int OP_W     = 2;
    localparam int BLK_W    = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 13;

    // Block count after reset, and the first block an allocate may hand out.
    localparam logic [CFG_W-1:0] CFG_RESET_BLOCKS  = 13'd4096;
    localparam int               FIRST_ALLOC_BLOCK = 2;

    // Operation codes of a request.
    typedef enum logic [OP_W-1:0] {
        OP_QUERY = 2'd0,
        OP_FREE  = 2'd1,
        OP_ALLOC = 2'd2
    } fbba_op_t;

    // Status codes of a result.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NO_FREE   = 2'd1,
        STS_BAD_BLOCK = 2'd2
    } fbba_status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_FREE,
        ST_SCAN
    } fbba_state_t;

endpackage

// ===== design/free_block_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_core: first-fit free block bitmap allocator
// A set bit in the bitmap means the block is free. Queries, frees and
// first-fit allocations run under a small sequencer around one memory.
//
// Channel   Direction  Signals                               Handshake
// request   in         start, operation, block_number        start && !busy
// result    out        done, status, allocated_block, is_free done strobe, 1 cycle
// config    in         cfg_we, cfg_data                      cfg_we
//
// A query or a free first reads its bitmap word into the read register,
// then registers the result strobe; requests that fail the range check
// register it straight from the idle state. An allocate reads one bitmap
// word per cycle through the single read port and tests it with one
// lowest-set-bit encoder. After reset a clearing pass writes MAX_BLOCKS /
// MAP_WORD_BITS words with busy high. Results cannot be stalled.
// MAP_WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator_core #(
    parameter int MAX_BLOCKS    = fbba_pkg::DEF_MAX_BLOCKS,
    parameter int MAP_WORD_BITS = fbba_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fbba_pkg::OP_W-1:0]     operation,
    input  logic [fbba_pkg::BLK_W-1:0]    block_number,
    output logic                          done,
    output logic [fbba_pkg::STATUS_W-1:0] status,
    output logic [fbba_pkg::BLK_W-1:0]    allocated_block,
    output logic                          is_free,
    input  logic                          cfg_we,
    input  logic [fbba_pkg::CFG_W-1:0]    cfg_data
);

    localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int LIM_W     = ($clog2(MAX_BLOCKS + 1) > fbba_pkg::CFG_W) ?
                               $clog2(MAX_BLOCKS + 1) : fbba_pkg::CFG_W;
    localparam logic [AW-1:0] LAST_MEM_ADDR = AW'(MAP_WORDS - 1);

    // Sequencer and request registers.
    fbba_pkg::fbba_state_t state_reg, state_next;
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic [fbba_pkg::BLK_W-1:0]   blk_reg, blk_next;
    logic [AW:0]                  scan_addr_reg, scan_addr_next;
    logic [AW-1:0]                chk_addr_reg, chk_addr_next;
    logic                         pend_reg, pend_next;
    logic [fbba_pkg::CFG_W-1:0]   total_blocks_reg;

    // Result registers.
    logic                          done_reg, done_next;
    logic [fbba_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fbba_pkg::BLK_W-1:0]    alloc_reg, alloc_next;
    logic                          is_free_reg, is_free_next;

    // Bitmap memory and its ports.
    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] rd_data_reg;
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;

    // Derived limits and addresses.
    logic [LIM_W-1:0]         lim, lim_m1;
    logic [AW-1:0]            last_word;
    logic                     in_range;
    logic [AW-1:0]            in_word, blk_word;
    logic [BIT_W-1:0]         blk_bit, lim_bit;
    logic [31:0]              in_ext, blk_ext, lim_ext;

    // Scan word test.
    logic [MAP_WORD_BITS-1:0] scan_mask, cand, lowbit;
    logic [BIT_W-1:0]         low_idx;
    logic                     found;
    logic [31:0]              alloc_full;

    // Effective block limit and the word holding its last block.
    always_comb
    begin
        lim = (LIM_W'(total_blocks_reg) > LIM_W'(MAX_BLOCKS)) ?
              LIM_W'(MAX_BLOCKS) : LIM_W'(total_blocks_reg);
        lim_m1    = lim - LIM_W'(1);
        lim_ext   = 32'(lim_m1);
        last_word = AW'(lim_ext >> BIT_W);
        lim_bit   = lim_m1[BIT_W-1:0];
        in_range  = LIM_W'(block_number) < lim;
        in_ext    = 32'(block_number);
        in_word   = AW'(in_ext >> BIT_W);
        blk_ext   = 32'(blk_reg);
        blk_word  = AW'(blk_ext >> BIT_W);
        blk_bit   = blk_reg[BIT_W-1:0];
    end

    // Mask the word under test to blocks 2 .. limit-1 and find its lowest set bit.
    always_comb
    begin
        scan_mask = '1;
        if (chk_addr_reg == '0)
        begin
            scan_mask = scan_mask & ({MAP_WORD_BITS{1'b1}} << fbba_pkg::FIRST_ALLOC_BLOCK);
        end
        if (chk_addr_reg == last_word)
        begin
            scan_mask = scan_mask &
                        ({MAP_WORD_BITS{1'b1}} >> (BIT_W'(MAP_WORD_BITS - 1) - lim_bit));
        end
        cand    = rd_data_reg & scan_mask;
        lowbit  = cand & (~cand + MAP_WORD_BITS'(1));
        found   = |cand;
        low_idx = '0;
        for (int j = 0; j < MAP_WORD_BITS; j++)
        begin
            if (lowbit[j])
            begin
                low_idx = low_idx | BIT_W'(j);
            end
        end
        alloc_full = (32'(chk_addr_reg) << BIT_W) | 32'(low_idx);
    end

    // Sequencer: next state, memory controls and result values.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        blk_next       = blk_reg;
        scan_addr_next = scan_addr_reg;
        chk_addr_next  = chk_addr_reg;
        pend_next      = pend_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        alloc_next     = alloc_reg;
        is_free_next   = is_free_reg;
        mem_we         = 1'b0;
        mem_waddr      = blk_word;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = in_word;

        unique case (state_reg)
            fbba_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_MEM_ADDR)
                begin
                    state_next = fbba_pkg::ST_IDLE;
                end
            end

            fbba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    blk_next     = block_number;
                    status_next  = fbba_pkg::STS_OK;
                    alloc_next   = '0;
                    is_free_next = 1'b0;
                    unique case (operation)
                        fbba_pkg::OP_QUERY:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                state_next = fbba_pkg::ST_QUERY;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        fbba_pkg::OP_FREE:
                        begin
                            if (in_range && (block_number != '0))
                            begin
                                mem_re     = 1'b1;
                                state_next = fbba_pkg::ST_FREE;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = fbba_pkg::STS_BAD_BLOCK;
                            end
                        end
                        fbba_pkg::OP_ALLOC:
                        begin
                            if (lim <= LIM_W'(fbba_pkg::FIRST_ALLOC_BLOCK))
                            begin
                                done_next   = 1'b1;
                                status_next = fbba_pkg::STS_NO_FREE;
                            end
                            else
                            begin
                                scan_addr_next = '0;
                                pend_next      = 1'b0;
                                state_next     = fbba_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = fbba_pkg::STS_BAD_BLOCK;
                        end
                    endcase
                end
            end

            fbba_pkg::ST_QUERY:
            begin
                done_next    = 1'b1;
                is_free_next = rd_data_reg[blk_bit];
                state_next   = fbba_pkg::ST_IDLE;
            end

            fbba_pkg::ST_FREE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = blk_word;
                mem_wdata  = rd_data_reg | (MAP_WORD_BITS'(1) << blk_bit);
                done_next  = 1'b1;
                state_next = fbba_pkg::ST_IDLE;
            end

            fbba_pkg::ST_SCAN:
            begin
                // Issue the next word read while the previous word is tested.
                pend_next = 1'b0;
                mem_raddr = scan_addr_reg[AW-1:0];
                if (scan_addr_reg <= {1'b0, last_word})
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    chk_addr_next  = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + (AW+1)'(1);
                end
                if (pend_reg)
                begin
                    if (found)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = chk_addr_reg;
                        mem_wdata   = rd_data_reg & ~lowbit;
                        done_next   = 1'b1;
                        status_next = fbba_pkg::STS_OK;
                        alloc_next  = alloc_full[fbba_pkg::BLK_W-1:0];
                        state_next  = fbba_pkg::ST_IDLE;
                    end
                    else if (chk_addr_reg == last_word)
                    begin
                        done_next   = 1'b1;
                        status_next = fbba_pkg::STS_NO_FREE;
                        state_next  = fbba_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = fbba_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= fbba_pkg::ST_CLEAR;
            clr_addr_reg     <= '0;
            pend_reg         <= 1'b0;
            done_reg         <= 1'b0;
            total_blocks_reg <= fbba_pkg::CFG_RESET_BLOCKS;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                total_blocks_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        status_reg    <= status_next;
        alloc_reg     <= alloc_next;
        is_free_reg   <= is_free_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    assign busy            = (state_reg != fbba_pkg::ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign allocated_block = alloc_reg;
    assign is_free         = is_free_reg;

    // An accepted request leads either to an immediate result or to a busy sequencer.
    a_accept_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy ^ done))
        else $error("accepted request neither produced a result nor started work");

    // A result only follows an accepted request or sequencer work.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result strobe without a request");

    // A failed request never hands out a block.
    a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != fbba_pkg::STS_OK)) |-> (allocated_block == '0))
        else $error("failed request returned a block number");

    // A free report always comes with ok status.
    a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_free) |-> (status == fbba_pkg::STS_OK))
        else $error("free report with error status");

    // The scan never tests a word beyond the last valid one.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fbba_pkg::ST_SCAN && pend_reg) |-> (chk_addr_reg <= last_word))
        else $error("scan tested a word past the block limit");

endmodule

// ===== verif/tb_free_block_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_block_bitmap_allocator_core: testbench of the block allocator core
// Sends query, free and allocate requests, keeps its own copy of the free
// map and the block limit, and checks every result field by field against
// the prediction, under several block limits and sender idle patterns.
// ----------------------------------------------------------------------------
module tb_free_block_bitmap_allocator_core;

    // Field types used for sized conversions.
    typedef logic [fbba_pkg::BLK_W-1:0] blk_t;
    typedef logic [fbba_pkg::CFG_W-1:0] cfg_t;

    localparam int                         MAP_BLOCKS    = fbba_pkg::DEF_MAX_BLOCKS;
    localparam logic [fbba_pkg::OP_W-1:0]  OP_UNUSED     = 2'd3;
    localparam logic [fbba_pkg::CFG_W-1:0] LIMIT_WIDEST  = 13'd8191;
    localparam logic [fbba_pkg::CFG_W-1:0] LIMIT_SMALL   = 13'd64;
    localparam int                         CYCLE_LIMIT   = 600000;
    localparam int                         RECENT_DEPTH  = 16;
    localparam int                         RANDOM_COUNT  = 150;
    localparam int                         SETTLE_CYCLES = 140;

    // One predicted result.
    typedef struct packed {
        logic [fbba_pkg::STATUS_W-1:0] status;
        logic [fbba_pkg::BLK_W-1:0]    allocated_block;
        logic                          is_free;
    } alloc_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [fbba_pkg::OP_W-1:0]     operation;
    logic [fbba_pkg::BLK_W-1:0]    block_number;
    logic                          done;
    logic [fbba_pkg::STATUS_W-1:0] status;
    logic [fbba_pkg::BLK_W-1:0]    allocated_block;
    logic                          is_free;
    logic                          cfg_we;
    logic [fbba_pkg::CFG_W-1:0]    cfg_data;

    // Predicted state of the block.
    bit                         block_free_model [MAP_BLOCKS];
    logic [fbba_pkg::CFG_W-1:0] block_limit_model;

    alloc_result_t pending_results[$];
    alloc_result_t head_result;
    int unsigned   touched_blocks[$];
    int unsigned   fail_count;
    int unsigned   cycle_count;
    int unsigned   idle_pct;

    free_block_bitmap_allocator_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .block_number    (block_number),
        .done            (done),
        .status          (status),
        .allocated_block (allocated_block),
        .is_free         (is_free),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run ends with a failure if it takes far longer than expected.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Effective block limit: the register value clipped to the map size.
    function automatic int unsigned usable_blocks();
        return (block_limit_model < MAP_BLOCKS) ? block_limit_model : MAP_BLOCKS;
    endfunction

    // Applies one request to the predicted bitmap and returns its result.
    function automatic alloc_result_t predict_request(
        input logic [fbba_pkg::OP_W-1:0]  op,
        input logic [fbba_pkg::BLK_W-1:0] blk);
        alloc_result_t res;
        int unsigned   lim;
        int unsigned   b;
        bit            found;
        res   = '0;
        lim   = usable_blocks();
        found = 1'b0;
        case (op)
            fbba_pkg::OP_QUERY:
            begin
                res.status  = fbba_pkg::STS_OK;
                res.is_free = (blk < lim) && block_free_model[blk];
            end
            fbba_pkg::OP_FREE:
            begin
                if (blk == 0 || blk >= lim)
                    res.status = fbba_pkg::STS_BAD_BLOCK;
                else
                begin
                    res.status            = fbba_pkg::STS_OK;
                    block_free_model[blk] = 1'b1;
                end
            end
            fbba_pkg::OP_ALLOC:
            begin
                // First fit: lowest free block from the first allocatable one.
                res.status = fbba_pkg::STS_NO_FREE;
                for (b = fbba_pkg::FIRST_ALLOC_BLOCK; b < lim && !found; b++)
                begin
                    if (block_free_model[b])
                    begin
                        block_free_model[b]  = 1'b0;
                        res.status           = fbba_pkg::STS_OK;
                        res.allocated_block  = b[fbba_pkg::BLK_W-1:0];
                        found                = 1'b1;
                    end
                end
            end
            default:
                res.status = fbba_pkg::STS_BAD_BLOCK;
        endcase
        return res;
    endfunction

    // Block number for a random request, biased toward recently used blocks.
    function automatic logic [fbba_pkg::BLK_W-1:0] pick_block(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return blk_t'($urandom_range(0, 1));
        if (r < 18)
            return blk_t'($urandom_range(0, MAP_BLOCKS - 1));
        if (r < 40 && touched_blocks.size() != 0)
            return blk_t'(touched_blocks[$urandom_range(0, touched_blocks.size() - 1)]);
        return blk_t'($urandom_range(0, lim - 1));
    endfunction

    // Sends one request, records its prediction, then idles at random.
    task automatic send_request(input logic [fbba_pkg::OP_W-1:0]  op,
                                input logic [fbba_pkg::BLK_W-1:0] blk);
        alloc_result_t res;
        start        <= 1'b1;
        operation    <= op;
        block_number <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = predict_request(op, blk);
        pending_results.push_back(res);

        // Keep a short history of freed and allocated blocks.
        if (op == fbba_pkg::OP_FREE ||
            (op == fbba_pkg::OP_ALLOC && res.status == fbba_pkg::STS_OK))
        begin
            touched_blocks.push_back(op == fbba_pkg::OP_FREE ? 32'(blk) :
                                     32'(res.allocated_block));
            if (touched_blocks.size() > RECENT_DEPTH)
                touched_blocks.delete(0);
        end

        // Random sender gaps, now and then long enough to outlast a scan.
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 140)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Holds off new requests until every result is in and the block is idle.
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Writes the block limit register while the block is idle.
    task automatic write_block_limit(input logic [fbba_pkg::CFG_W-1:0] value);
        wait_results_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we            <= 1'b0;
        block_limit_model  = value;
    endtask

    // Runs a stream of random requests at the current limit and idle rate.
    task automatic run_random_traffic(input int unsigned count);
        int unsigned               n;
        int unsigned               r;
        logic [fbba_pkg::OP_W-1:0] op;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op = fbba_pkg::OP_FREE;
            else if (r < 75)
                op = fbba_pkg::OP_ALLOC;
            else if (r < 95)
                op = fbba_pkg::OP_QUERY;
            else
                op = OP_UNUSED;
            send_request(op, pick_block(usable_blocks()));
        end
        wait_results_drained();
    endtask

    // After reset every block is in use and nothing can be allocated.
    task automatic test_reset_state();
        send_request(fbba_pkg::OP_QUERY, 12'd0);
        send_request(fbba_pkg::OP_QUERY, 12'd4095);
        send_request(fbba_pkg::OP_ALLOC, 12'd0);
        send_request(OP_UNUSED, 12'd4095);
    endtask

    // Frees, including block zero and a block that is already free.
    task automatic test_free_and_query();
        send_request(fbba_pkg::OP_FREE, 12'd0);
        send_request(fbba_pkg::OP_FREE, 12'd1);
        send_request(fbba_pkg::OP_FREE, 12'd4095);
        send_request(fbba_pkg::OP_FREE, 12'd4095);
        send_request(fbba_pkg::OP_FREE, 12'd2);
        send_request(fbba_pkg::OP_FREE, 12'd33);
        send_request(fbba_pkg::OP_QUERY, 12'd4095);
    endtask

    // Allocation takes the lowest free block and never hands out block one.
    task automatic test_first_fit_alloc();
        send_request(fbba_pkg::OP_ALLOC, 12'd4095);
        send_request(fbba_pkg::OP_ALLOC, 12'd0);
        send_request(fbba_pkg::OP_ALLOC, 12'd1);
        send_request(fbba_pkg::OP_ALLOC, 12'd0);
    endtask

    // Limits above the map size, a reduced limit and the smallest limits.
    task automatic test_block_limit();
        write_block_limit(LIMIT_WIDEST);
        send_request(fbba_pkg::OP_FREE, 12'd4095);
        send_request(fbba_pkg::OP_QUERY, 12'd4095);
        write_block_limit(13'd100);
        send_request(fbba_pkg::OP_QUERY, 12'd4095);
        send_request(fbba_pkg::OP_FREE, 12'd100);
        send_request(fbba_pkg::OP_FREE, 12'd99);
        send_request(fbba_pkg::OP_ALLOC, 12'd0);
        write_block_limit(13'd2);
        send_request(fbba_pkg::OP_ALLOC, 12'd0);
        send_request(fbba_pkg::OP_FREE, 12'd2);
        write_block_limit(13'd3);
        send_request(fbba_pkg::OP_FREE, 12'd2);
        send_request(fbba_pkg::OP_ALLOC, 12'd0);
    endtask

    // Back-to-back random requests over the full map.
    task automatic test_random_no_idle();
        idle_pct = 0;
        write_block_limit(fbba_pkg::CFG_RESET_BLOCKS);
        run_random_traffic(RANDOM_COUNT);
    endtask

    // Small map, where allocations often run out, with a gappy sender.
    task automatic test_random_sender_idle();
        idle_pct = 50;
        write_block_limit(LIMIT_SMALL);
        run_random_traffic(RANDOM_COUNT);
    endtask

    // Widest register value, which clips to the map size.
    task automatic test_random_wide_limit();
        idle_pct = 0;
        write_block_limit(LIMIT_WIDEST);
        run_random_traffic(RANDOM_COUNT);
    endtask

    // Random limit with a moderately idle sender.
    task automatic test_random_mixed_idle();
        idle_pct = 29;
        write_block_limit(cfg_t'($urandom_range(3, MAP_BLOCKS)));
        run_random_traffic(RANDOM_COUNT);
    endtask

    // Each result strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, allocated_block %0d, is_free %0d",
                       status, allocated_block, is_free);
                fail_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (status !== head_result.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           head_result.status, status);
                    fail_count++;
                end
                if (allocated_block !== head_result.allocated_block)
                begin
                    $error("allocated_block mismatch: expected %0d, actual %0d",
                           head_result.allocated_block, allocated_block);
                    fail_count++;
                end
                if (is_free !== head_result.is_free)
                begin
                    $error("is_free mismatch: expected %0d, actual %0d",
                           head_result.is_free, is_free);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed tests, random tests, final verdict.
    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        operation    <= fbba_pkg::OP_QUERY;
        block_number <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        fail_count    = 0;
        idle_pct      = 0;
        block_limit_model = fbba_pkg::CFG_RESET_BLOCKS;
        foreach (block_free_model[i])
            block_free_model[i] = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_free_and_query();
        test_first_fit_alloc();
        test_block_limit();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_wide_limit();
        test_random_mixed_idle();

        // Let any stray result show up before the verdict.
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fbba_pkg.sv
design/free_block_bitmap_allocator_core.sv
verif/tb_free_block_bitmap_allocator_core.sv
